>>> rtl/mrcm_pkg.sv
// Shared types and constants for the min-position rank and cost store.
package mrcm_pkg;

  localparam int RANK_W     = 4;
  localparam int COST_W     = 32;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [RANK_W-1:0] RANK_MAX = '1;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ROBOTS    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRONTIERS = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OWN,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } mrcm_state_t;

  typedef struct packed {
    logic clear;
    logic own_load;
    logic cmp_en;
    logic skip;
  } mrcm_ctl_t;

endpackage

>>> rtl/mrcm_store.sv
// Simple dual-port distance and cost memory (one write port, one read port) with registered read data.
module mrcm_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 64
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/mrcm_rank_unit.sv
// Shared distance comparator and saturating rank counter.
module mrcm_rank_unit import mrcm_pkg::*; #(
  parameter int SW = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mrcm_ctl_t         ctl,
  input  logic [SW-1:0]     rd_dist,
  input  logic [SW-1:0]     rd_cost,
  output logic [RANK_W-1:0] rank_count,
  output logic              any_closer,
  output logic [SW-1:0]     own_cost
);

  logic [SW-1:0]     own_dist_r;
  logic [SW-1:0]     own_cost_r;
  logic [RANK_W-1:0] count_r;
  logic              any_r;
  logic              closer;

  assign closer = ctl.cmp_en && !ctl.skip && (rd_dist < own_dist_r);

  always_ff @(posedge clk) begin
    if (ctl.own_load) begin
      own_dist_r <= rd_dist;
      own_cost_r <= rd_cost;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      count_r <= '0;
      any_r   <= 1'b0;
    end else if (closer) begin
      any_r <= 1'b1;
      if (count_r != RANK_MAX) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  assign rank_count = count_r;
  assign any_closer = any_r;
  assign own_cost   = own_cost_r;

endmodule

>>> rtl/minpos_rank_cost_mask.sv
// Min-position rank and cost store: top level with sequencer and stream ports.
//
// A write transfer (tuser 0) stores one distance and cost entry; a new item is
// accepted on the next cycle. A query transfer (tuser 1) reads its own entry,
// then reads the distance of every robot in use for the same frontier through
// the single read port of the store, one robot per cycle, and compares each
// against its own distance in one shared comparator. A query keeps in_tready
// low while it steps through ST_OWN, ST_SCAN (one read per robot in use,
// robots_in_use capped at MAX_ROBOTS), ST_DRAIN and ST_DONE; an out-of-range
// query keeps it low only in ST_DONE. The result sits in an output register,
// so the next item is accepted while it waits; a query that finishes while an
// earlier result still waits holds in ST_DONE until that result is taken.
// Robot and frontier indexes map to store address robot * MAX_FRONTIERS +
// frontier. Entries that were never written read back undefined.
module minpos_rank_cost_mask import mrcm_pkg::*; #(
  parameter int MAX_ROBOTS    = 16,
  parameter int MAX_FRONTIERS = 256,
  parameter int VALUE_WIDTH   = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // tdata: robot[3:0], frontier[11:4], distance[43:12], cost[75:44], zero fill
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // tuser: func
  input  logic                  in_tuser,
  // tdata: rank_count[3:0], modified_cost[35:4], out_of_range[36], zero fill
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = MAX_ROBOTS * MAX_FRONTIERS;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = (VALUE_WIDTH < COST_W) ? VALUE_WIDTH : COST_W;
  localparam int KW    = $clog2(MAX_ROBOTS);
  localparam int NRW   = $clog2(MAX_ROBOTS + 1);
  localparam int NFW   = $clog2(MAX_FRONTIERS + 1);

  localparam logic [AW-1:0]     ROW_STEP    = AW'(MAX_FRONTIERS);
  localparam logic [COST_W-1:0] UNASSIGNED  = COST_W'({SW{1'b1}});

  mrcm_state_t state_r, state_nxt;

  logic [4:0]        cfg_robots_r;
  logic [8:0]        cfg_frontiers_r;
  logic [NRW-1:0]    rob_lim;
  logic [NFW-1:0]    fro_lim;

  logic [3:0]        in_robot;
  logic [7:0]        in_frontier;
  logic [31:0]       in_distance;
  logic [31:0]       in_cost;
  logic              in_xfer;
  logic              q_oor;

  logic [3:0]        robot_r;
  logic [7:0]        frontier_r;
  logic              oor_r;
  logic [KW-1:0]     k_r;
  logic [AW-1:0]     addr_r;
  logic              cmp_v_r;
  logic              cmp_skip_r;
  logic              last_issue;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [2*SW-1:0]   wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     own_addr;
  logic [2*SW-1:0]   rd_data;

  mrcm_ctl_t         ctl;
  logic [RANK_W-1:0] rank_count;
  logic              any_closer;
  logic [SW-1:0]     own_cost;

  logic              out_valid_r;
  logic [RANK_W-1:0] out_rank_r;
  logic [COST_W-1:0] out_cost_r;
  logic              out_oor_r;
  logic              out_load;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_robots_r    <= 5'd1;
      cfg_frontiers_r <= 9'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROBOTS:    cfg_robots_r    <= cfg_data[4:0];
        REG_FRONTIERS: cfg_frontiers_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rob_lim = (32'(cfg_robots_r) > 32'(MAX_ROBOTS)) ?
                   NRW'(MAX_ROBOTS) : NRW'(cfg_robots_r);
  assign fro_lim = (32'(cfg_frontiers_r) > 32'(MAX_FRONTIERS)) ?
                   NFW'(MAX_FRONTIERS) : NFW'(cfg_frontiers_r);

  // input unpack
  assign in_robot    = in_tdata[3:0];
  assign in_frontier = in_tdata[11:4];
  assign in_distance = in_tdata[43:12];
  assign in_cost     = in_tdata[75:44];

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign q_oor     = (32'(in_robot) >= 32'(rob_lim)) ||
                     (32'(in_frontier) >= 32'(fro_lim));

  // store write: drop writes outside the storage
  assign wr_en   = in_xfer && (in_tuser == FUNC_WRITE) &&
                   (32'(in_robot) < 32'(MAX_ROBOTS)) &&
                   (32'(in_frontier) < 32'(MAX_FRONTIERS));
  assign wr_addr = AW'(32'(in_robot) * 32'(MAX_FRONTIERS) + 32'(in_frontier));
  assign wr_data = {in_cost[SW-1:0], in_distance[SW-1:0]};

  assign own_addr   = AW'(32'(robot_r) * 32'(MAX_FRONTIERS) + 32'(frontier_r));
  assign rd_en      = (state_r == ST_OWN) || (state_r == ST_SCAN);
  assign rd_addr    = (state_r == ST_OWN) ? own_addr : addr_r;
  assign last_issue = (32'(k_r) + 32'd1 == 32'(rob_lim));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_tuser == FUNC_QUERY)) begin
          state_nxt = q_oor ? ST_DONE : ST_OWN;
        end
      end
      ST_OWN:  state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs to the rank unit
  always_comb begin
    ctl = '0;
    case (state_r)
      ST_OWN: ctl.clear = 1'b1;
      ST_SCAN: begin
        ctl.own_load = !cmp_v_r;
        ctl.cmp_en   = cmp_v_r;
        ctl.skip     = cmp_skip_r;
      end
      ST_DRAIN: begin
        ctl.cmp_en = cmp_v_r;
        ctl.skip   = cmp_skip_r;
      end
      default: ;
    endcase
  end

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cmp_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_SCAN) begin
        cmp_v_r <= 1'b1;
      end else begin
        cmp_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      robot_r    <= in_robot;
      frontier_r <= in_frontier;
      oor_r      <= q_oor;
    end
    if (state_r == ST_OWN) begin
      k_r    <= '0;
      addr_r <= AW'(frontier_r);
    end else if (state_r == ST_SCAN) begin
      k_r    <= k_r + 1'b1;
      addr_r <= addr_r + ROW_STEP;
    end
    cmp_skip_r <= (32'(k_r) == 32'(robot_r));
  end

  mrcm_store #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (2 * SW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mrcm_rank_unit #(
    .SW (SW)
  ) u_rank (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .rd_dist    (rd_data[SW-1:0]),
    .rd_cost    (rd_data[2*SW-1:SW]),
    .rank_count (rank_count),
    .any_closer (any_closer),
    .own_cost   (own_cost)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_oor_r  <= oor_r;
      out_rank_r <= oor_r ? '0 : rank_count;
      out_cost_r <= oor_r ? '1 : (any_closer ? UNASSIGNED : COST_W'(own_cost));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_oor_r, out_cost_r, out_rank_r};

endmodule
